@@ hw/rtl/y4ml_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// y4ml_pkg
// Types, byte codes and helpers shared by the YUV4MPEG2 luma extractor.
// ----------------------------------------------------------------------------
package y4ml_pkg;

    // Parser phases, one-hot
    typedef enum logic [6:0] {
        PH_MAGIC  = 7'b0000001,
        PH_GAP    = 7'b0000010,
        PH_TOKEN  = 7'b0000100,
        PH_FLINE  = 7'b0001000,
        PH_LUMA   = 7'b0010000,
        PH_CHROMA = 7'b0100000,
        PH_ERROR  = 7'b1000000
    } t_phase;

    // Result kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // Error codes
    localparam logic [1:0] ERR_CHROMA    = 2'd0;
    localparam logic [1:0] ERR_INTERLACE = 2'd1;
    localparam logic [1:0] ERR_TAG       = 2'd2;
    localparam logic [1:0] ERR_NUMBER    = 2'd3;

    // Stream bytes
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_W  = 8'h57;
    localparam logic [7:0] CH_H  = 8'h48;
    localparam logic [7:0] CH_C  = 8'h43;
    localparam logic [7:0] CH_I  = 8'h49;
    localparam logic [7:0] CH_F  = 8'h46;
    localparam logic [7:0] CH_A  = 8'h41;
    localparam logic [7:0] CH_X  = 8'h58;
    localparam logic [7:0] CH_P  = 8'h70;

    // Length of the "420jpeg" chroma value
    localparam int         MATCH_W    = 3;
    localparam logic [2:0] CHROMA_LEN = 3'd7;

    typedef struct packed {
        logic       kind;
        logic [7:0] pixel;
        logic       frame_last;
        logic [1:0] error_code;
    } t_result;

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, 8'h09, 8'h0D, 8'h0B, 8'h0C};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30 : 8'h39]};
    endfunction

    // Expected characters of "420jpeg"
    function automatic logic [7:0] chroma_char(input logic [MATCH_W-1:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h34;
            3'd1:    ch = 8'h32;
            3'd2:    ch = 8'h30;
            3'd3:    ch = 8'h6A;
            3'd4:    ch = 8'h70;
            3'd5:    ch = 8'h65;
            3'd6:    ch = 8'h67;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/y4ml_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// y4ml_in_if
// Byte stream channel: valid/ready with one raw stream byte per request.
// ----------------------------------------------------------------------------
interface y4ml_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/y4ml_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// y4ml_out_if
// Result channel: valid/ready carrying a luma pixel or an error request.
// ----------------------------------------------------------------------------
interface y4ml_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] pixel;
    logic       frame_last;
    logic [1:0] error_code;

    modport source (output valid, output kind, output pixel, output frame_last,
                    output error_code, input ready);
    modport sink   (input valid, input kind, input pixel, input frame_last,
                    input error_code, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/y4ml_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// y4ml_parser
// Header tag parser, frame sequencer and luma/chroma byte counters.
// ----------------------------------------------------------------------------
module y4ml_parser #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire logic [7:0]         i_byte,
    output y4ml_pkg::t_result       o_res,
    output logic                    o_res_valid
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int NUM_W  = DIM_W + 4;
    localparam int NPIX_W = 2 * DIM_W;
    localparam logic [NUM_W-1:0] MAX_NUM = NUM_W'(MAX_DIM);
    localparam logic [DIM_W-1:0] MAX_VAL = DIM_W'(MAX_DIM);

    y4ml_pkg::t_phase r_phase, n_phase;
    logic                        r_magic_started, n_magic_started;
    logic [7:0]                  r_tag, n_tag;
    logic                        r_num_ok, n_num_ok;
    logic                        r_num_done, n_num_done;
    logic [DIM_W-1:0]            r_num, n_num;
    logic [y4ml_pkg::MATCH_W-1:0] r_match_len, n_match_len;
    logic                        r_match_bad, n_match_bad;
    logic [DIM_W-1:0]            r_w, n_w;
    logic [DIM_W-1:0]            r_h, n_h;
    logic [NPIX_W-1:0]           r_npix;
    logic [NPIX_W-1:0]           r_luma_left, n_luma_left;
    logic [NPIX_W-1:0]           r_chroma_left, n_chroma_left;

    logic                        sep;
    logic                        tok_err;
    logic [1:0]                  tok_code;
    logic [NUM_W-1:0]            num_x10;

    assign sep = (i_byte == y4ml_pkg::CH_LF) || y4ml_pkg::is_space(i_byte);
    assign num_x10 = ({4'b0, r_num} << 3) + ({4'b0, r_num} << 1)
                   + {{DIM_W{1'b0}}, i_byte[3:0]};

    // Check the token that ends with the current separator
    always_comb begin
        tok_err  = 1'b0;
        tok_code = y4ml_pkg::ERR_CHROMA;
        case (r_tag)
            y4ml_pkg::CH_W, y4ml_pkg::CH_H: begin
                if (!r_num_ok) begin
                    tok_err  = 1'b1;
                    tok_code = y4ml_pkg::ERR_NUMBER;
                end
            end
            y4ml_pkg::CH_C: begin
                if (r_match_bad || r_match_len != y4ml_pkg::CHROMA_LEN) begin
                    tok_err  = 1'b1;
                    tok_code = y4ml_pkg::ERR_CHROMA;
                end
            end
            y4ml_pkg::CH_I: begin
                if (r_match_bad || r_match_len != 3'd1) begin
                    tok_err  = 1'b1;
                    tok_code = y4ml_pkg::ERR_INTERLACE;
                end
            end
            y4ml_pkg::CH_F, y4ml_pkg::CH_A, y4ml_pkg::CH_X: ;
            default: begin
                tok_err  = 1'b1;
                tok_code = y4ml_pkg::ERR_TAG;
            end
        endcase
    end

    always_comb begin
        n_phase         = r_phase;
        n_magic_started = r_magic_started;
        n_tag           = r_tag;
        n_num_ok        = r_num_ok;
        n_num_done      = r_num_done;
        n_num           = r_num;
        n_match_len     = r_match_len;
        n_match_bad     = r_match_bad;
        n_w             = r_w;
        n_h             = r_h;
        n_luma_left     = r_luma_left;
        n_chroma_left   = r_chroma_left;
        o_res_valid     = 1'b0;
        o_res           = '0;

        if (i_step) begin
            case (r_phase)
                y4ml_pkg::PH_MAGIC: begin
                    if (!r_magic_started) begin
                        if (!sep) begin
                            n_magic_started = 1'b1;
                        end
                    end else if (i_byte == y4ml_pkg::CH_LF) begin
                        n_phase = y4ml_pkg::PH_FLINE;
                    end else if (y4ml_pkg::is_space(i_byte)) begin
                        n_phase = y4ml_pkg::PH_GAP;
                    end
                end
                y4ml_pkg::PH_GAP: begin
                    if (i_byte == y4ml_pkg::CH_LF) begin
                        n_phase = y4ml_pkg::PH_FLINE;
                    end else if (!y4ml_pkg::is_space(i_byte)) begin
                        n_tag       = i_byte;
                        n_num_ok    = 1'b0;
                        n_num_done  = 1'b0;
                        n_num       = '0;
                        n_match_len = '0;
                        n_match_bad = 1'b0;
                        n_phase     = y4ml_pkg::PH_TOKEN;
                    end
                end
                y4ml_pkg::PH_TOKEN: begin
                    if (sep) begin
                        if (tok_err) begin
                            n_phase                = y4ml_pkg::PH_ERROR;
                            o_res_valid            = 1'b1;
                            o_res.kind             = y4ml_pkg::KIND_ERROR;
                            o_res.error_code       = tok_code;
                        end else begin
                            if (r_tag == y4ml_pkg::CH_W) begin
                                n_w = r_num;
                            end else if (r_tag == y4ml_pkg::CH_H) begin
                                n_h = r_num;
                            end
                            n_phase = (i_byte == y4ml_pkg::CH_LF) ? y4ml_pkg::PH_FLINE
                                                                  : y4ml_pkg::PH_GAP;
                        end
                    end else begin
                        case (r_tag)
                            y4ml_pkg::CH_W, y4ml_pkg::CH_H: begin
                                // Only the leading run of digits counts
                                if (!r_num_done && y4ml_pkg::is_digit(i_byte)) begin
                                    n_num    = (num_x10 > MAX_NUM) ? MAX_VAL
                                                                   : num_x10[DIM_W-1:0];
                                    n_num_ok = 1'b1;
                                end else begin
                                    n_num_done = 1'b1;
                                end
                            end
                            y4ml_pkg::CH_C: begin
                                if (r_match_len < y4ml_pkg::CHROMA_LEN &&
                                    y4ml_pkg::chroma_char(r_match_len) == i_byte) begin
                                    n_match_len = r_match_len + 3'd1;
                                end else begin
                                    n_match_bad = 1'b1;
                                end
                            end
                            y4ml_pkg::CH_I: begin
                                if (r_match_len == 3'd0 && i_byte == y4ml_pkg::CH_P) begin
                                    n_match_len = 3'd1;
                                end else begin
                                    n_match_bad = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                y4ml_pkg::PH_FLINE: begin
                    if (i_byte == y4ml_pkg::CH_LF) begin
                        n_luma_left   = r_npix;
                        n_chroma_left = {1'b0, r_npix[NPIX_W-1:2], 1'b0};
                        n_phase       = (r_npix != '0) ? y4ml_pkg::PH_LUMA
                                                       : y4ml_pkg::PH_FLINE;
                    end
                end
                y4ml_pkg::PH_LUMA: begin
                    n_luma_left      = r_luma_left - NPIX_W'(1);
                    o_res_valid      = 1'b1;
                    o_res.kind       = y4ml_pkg::KIND_PIXEL;
                    o_res.pixel      = i_byte;
                    o_res.frame_last = (r_luma_left == NPIX_W'(1));
                    if (r_luma_left == NPIX_W'(1)) begin
                        n_phase = (r_chroma_left != '0) ? y4ml_pkg::PH_CHROMA
                                                        : y4ml_pkg::PH_FLINE;
                    end
                end
                y4ml_pkg::PH_CHROMA: begin
                    if (r_chroma_left != '0) begin
                        n_chroma_left = r_chroma_left - NPIX_W'(1);
                    end
                    if (r_chroma_left <= NPIX_W'(1)) begin
                        n_phase = y4ml_pkg::PH_FLINE;
                    end
                end
                y4ml_pkg::PH_ERROR: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= y4ml_pkg::PH_MAGIC;
            r_magic_started <= 1'b0;
            r_tag           <= '0;
            r_num_ok        <= 1'b0;
            r_num_done      <= 1'b0;
            r_num           <= '0;
            r_match_len     <= '0;
            r_match_bad     <= 1'b0;
            r_w             <= '0;
            r_h             <= '0;
            r_npix          <= '0;
            r_luma_left     <= '0;
            r_chroma_left   <= '0;
        end else begin
            r_phase         <= n_phase;
            r_magic_started <= n_magic_started;
            r_tag           <= n_tag;
            r_num_ok        <= n_num_ok;
            r_num_done      <= n_num_done;
            r_num           <= n_num;
            r_match_len     <= n_match_len;
            r_match_bad     <= n_match_bad;
            r_w             <= n_w;
            r_h             <= n_h;
            // Hold the frame size ready for the very next frame line
            r_npix          <= NPIX_W'(n_w) * NPIX_W'(n_h);
            r_luma_left     <= n_luma_left;
            r_chroma_left   <= n_chroma_left;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/y4m_luma_extractor_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// y4m_luma_extractor_unit
// Extracts the luma planes of a 4:2:0 progressive YUV4MPEG2 byte stream.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock unless stalled, and gives each luma byte as a
// pixel request, with frame_last on the last byte of a frame. Header tags W
// and H set the frame size (saturating at MAX_DIM); C must read 420jpeg and I
// must read p; F, A and X are skipped; any other tag, or a non-numeric W or H
// value, gives a single error request, after which all input is swallowed
// until reset. A byte taken in waits in the input register while the parser
// works on it, and its result is then stored in the result register. Only
// back-pressure on the result side slows the input, once the input register
// holds a byte that cannot move on. The
// W*H frame size is kept in its own register, refreshed every cycle from the
// multiplier, so a frame line may start right after the header ends.
// ----------------------------------------------------------------------------
module y4m_luma_extractor_unit #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    y4ml_in_if.sink     i_in,
    y4ml_out_if.source  o_out
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_out_valid;
    y4ml_pkg::t_result  r_out;

    logic               adv;
    logic               step;
    logic               res_valid;
    y4ml_pkg::t_result  res;

    // Advance when the result register is free or being emptied
    assign adv        = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || adv;
    assign step       = r_in_valid && adv;

    y4ml_parser #(
        .MAX_DIM (MAX_DIM)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .o_res       (res),
        .o_res_valid (res_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= step && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.kind       = r_out.kind;
    assign o_out.pixel      = r_out.pixel;
    assign o_out.frame_last = r_out.frame_last;
    assign o_out.error_code = r_out.error_code;

endmodule
`default_nettype wire
